// ===== sv/isort_pkg.sv =====
`timescale 1ns / 1ps

package isort_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_set;
        logic                     overflow;
    } t_out_item;

endpackage

// ===== sv/isort_store.sv =====
`timescale 1ns / 1ps

module isort_store #(
    parameter int DEPTH = isort_pkg::MAX_ITEMS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [AW-1:0]                       i_waddr,
    input  logic signed [isort_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]                       i_raddr,
    output logic signed [isort_pkg::DATA_W-1:0] o_rdata
);

    logic signed [isort_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [isort_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/isort_seq.sv =====
`timescale 1ns / 1ps

module isort_seq #(
    parameter int MAX_ITEMS = isort_pkg::MAX_ITEMS_DEF,
    parameter int AW        = $clog2(MAX_ITEMS)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  isort_pkg::t_in_item                 i_item,
    output logic                                busy,
    output logic                                o_we,
    output logic [AW-1:0]                       o_waddr,
    output logic signed [isort_pkg::DATA_W-1:0] o_wdata,
    output logic [AW-1:0]                       o_raddr,
    input  logic signed [isort_pkg::DATA_W-1:0] i_rdata,
    output logic                                o_valid,
    output isort_pkg::t_out_item                o_result
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] ONE     = CW'(1);
    localparam logic [CW-1:0] TWO     = CW'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_dropped, n_dropped;
    isort_pkg::t_in_item r_item, n_item;
    logic                r_emit_v, n_emit_v;
    logic                r_emit_last, n_emit_last;
    logic                r_emit_ovf, n_emit_ovf;
    logic [CW-1:0]       w_pos_m1;
    logic [CW-1:0]       w_pos_m2;
    logic [CW-1:0]       w_cnt_m1;
    logic                w_greater;

    assign w_pos_m1  = r_pos - ONE;
    assign w_pos_m2  = r_pos - TWO;
    assign w_cnt_m1  = r_count - ONE;
    assign w_greater = i_rdata > r_item.value;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_dropped   = r_dropped;
        n_item      = r_item;
        n_emit_v    = 1'b0;
        n_emit_last = 1'b0;
        n_emit_ovf  = r_emit_ovf;
        o_we        = 1'b0;
        o_waddr     = '0;
        o_wdata     = r_item.value;
        o_raddr     = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    n_idx  = '0;
                    if (r_count == MAX_CNT) begin
                        n_dropped = 1'b1;
                        if (i_item.last) begin
                            n_state = S_EMIT;
                        end
                    end else if (r_count == '0) begin
                        o_we    = 1'b1;
                        o_waddr = '0;
                        o_wdata = i_item.value;
                        n_count = ONE;
                        if (i_item.last) begin
                            n_state = S_EMIT;
                        end
                    end else begin
                        // fetch the current top entry, the hole sits just above it
                        o_raddr = w_cnt_m1[AW-1:0];
                        n_pos   = r_count;
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                o_we = 1'b1;
                if (w_greater) begin
                    o_waddr = r_pos[AW-1:0];
                    o_wdata = i_rdata;
                    n_pos   = w_pos_m1;
                    if (r_pos == ONE) begin
                        n_state = S_PLACE;
                    end else begin
                        o_raddr = w_pos_m2[AW-1:0];
                    end
                end else begin
                    o_waddr = r_pos[AW-1:0];
                    o_wdata = r_item.value;
                    n_count = r_count + ONE;
                    n_idx   = '0;
                    n_state = r_item.last ? S_EMIT : S_IDLE;
                end
            end
            S_PLACE: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = r_item.value;
                n_count = r_count + ONE;
                n_idx   = '0;
                n_state = r_item.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                o_raddr     = r_idx[AW-1:0];
                n_emit_v    = 1'b1;
                n_emit_last = (r_idx == w_cnt_m1);
                n_emit_ovf  = r_dropped;
                n_idx       = r_idx + ONE;
                if (r_idx == w_cnt_m1) begin
                    n_state   = S_IDLE;
                    n_count   = '0;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_emit_v    <= 1'b0;
            r_emit_last <= 1'b0;
            r_emit_ovf  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_emit_v    <= n_emit_v;
            r_emit_last <= n_emit_last;
            r_emit_ovf  <= n_emit_ovf;
        end
        r_pos  <= n_pos;
        r_idx  <= n_idx;
        r_item <= n_item;
    end

    assign busy                  = (r_state != S_IDLE);
    assign o_valid               = r_emit_v;
    assign o_result.sorted_value = i_rdata;
    assign o_result.end_of_set   = r_emit_last;
    assign o_result.overflow     = r_emit_ovf;

endmodule

// ===== sv/insertion_sort_engine_core.sv =====
`timescale 1ns / 1ps
// insertion: a direct write when the store is empty, a drop when it is full, else accept,
// one move per entry shifted up and one write of the new value, the shift loop stepping
// down through the store one entry per cycle
// item marked last: then MAX_ITEMS or fewer results on back-to-back cycles, read via
// the emit state and registered store port; receiver cannot stall, busy gates start
// synchronous active-low reset empties the store count and drop flag, no clearing pass

module insertion_sort_engine_core #(
    parameter int MAX_ITEMS = isort_pkg::MAX_ITEMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  isort_pkg::t_in_item  i_item,
    output logic                 busy,
    output logic                 o_valid,
    output isort_pkg::t_out_item o_result
);

    localparam int AW = $clog2(MAX_ITEMS);

    logic                                we;
    logic [AW-1:0]                       waddr;
    logic signed [isort_pkg::DATA_W-1:0] wdata;
    logic [AW-1:0]                       raddr;
    logic signed [isort_pkg::DATA_W-1:0] rdata;

    isort_seq #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr  (raddr),
        .i_rdata  (rdata),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    isort_store #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

// ===== sv/isort_chk.sv =====
`timescale 1ns / 1ps

module isort_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input isort_pkg::t_in_item  i_item,
    input logic                 busy,
    input logic                 o_valid,
    input isort_pkg::t_out_item o_result
);

    // a set goes out as one unbroken burst
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.end_of_set |=> o_valid)
        else $error("gap inside a result burst");

    a_gap_after_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.end_of_set |=> !o_valid)
        else $error("result right after end of set");

    a_busy_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.end_of_set |-> busy)
        else $error("not busy while a set is being emitted");

    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.end_of_set |=> o_result.overflow == $past(o_result.overflow))
        else $error("overflow changed within a set");

    a_no_result_mid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_item.last |=> !o_valid)
        else $error("result after a transfer not marked last");

endmodule

bind insertion_sort_engine_core isort_chk u_isort_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
